>>> sv/tile_dedup_flip_match_macros.svh
// Assertion macros for the tile dedup block.
`ifndef TILE_DEDUP_FLIP_MATCH_MACROS_SVH
`define TILE_DEDUP_FLIP_MATCH_MACROS_SVH
`ifndef SYNTHESIS
`define TDFM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TDFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TDFM_ASSERT_IMPL(label, ante, cons)
`define TDFM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/tdfm_pkg.sv
// Shared types, constants and helpers for the tile dedup block.
`timescale 1ns / 1ps
`default_nettype none
package tdfm_pkg;
  localparam int ROW_W        = 64;
  localparam int TILE_ROWS    = 8;
  localparam int SLOT_W       = 11;
  localparam int MAX_TILES_DEF = 1024;
  localparam int LANES        = 4;

  typedef enum logic [1:0] {
    ST_MATCHED = 2'd0,
    ST_STORED  = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_STORE, S_HOLD
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } lane_res_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              h;
    logic              v;
  } match_t;

  // reverse pixel order of one row
  function automatic logic [ROW_W-1:0] mirror_row(input logic [ROW_W-1:0] row,
                                                  input logic wide);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (wide) r[8*(7-i) +: 8] = row[8*i +: 8];
      else      r[4*(7-i) +: 4] = row[4*i +: 4];
    end
    return r;
  endfunction

  // search order: 4bpp id,v,h,hv; 8bpp id,h,v,hv
  function automatic logic lane_h(input logic [1:0] t, input logic wide);
    return wide ? t[0] : t[1];
  endfunction

  function automatic logic lane_v(input logic [1:0] t, input logic wide);
    return wide ? t[1] : t[0];
  endfunction
endpackage
`default_nettype wire

>>> sv/tdfm_lane.sv
// One compare lane: checks stored tiles against one flip of the new tile.
`timescale 1ns / 1ps
`default_nettype none
module tdfm_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic                            valid,
  input  logic [2:0]                      row,
  input  logic [tdfm_pkg::SLOT_W-1:0]     slot,
  input  logic [tdfm_pkg::ROW_W-1:0]      stored,
  input  logic [tdfm_pkg::ROW_W-1:0]      fwd_head,
  input  logic [tdfm_pkg::ROW_W-1:0]      rev_head,
  input  logic                            h,
  input  logic                            v,
  input  logic                            wide,
  output tdfm_pkg::lane_res_t             res
);
  logic [tdfm_pkg::ROW_W-1:0] src, expect_row;
  logic run_ok, run_now;

  assign src        = v ? rev_head : fwd_head;
  assign expect_row = h ? tdfm_pkg::mirror_row(src, wide) : src;
  assign run_now    = (stored == expect_row) && ((row == 3'd0) || run_ok);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      run_ok   <= 1'b0;
      res.hit  <= 1'b0;
      res.slot <= '0;
    end else if (valid) begin
      run_ok <= run_now;
      // slots come in ascending order, so the first hit is the lowest
      if (row == 3'd7 && run_now && !res.hit) begin
        res.hit  <= 1'b1;
        res.slot <= slot;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/tdfm_merge.sv
// Picks the winning lane in search order.
`timescale 1ns / 1ps
`default_nettype none
module tdfm_merge (
  input  tdfm_pkg::lane_res_t res [tdfm_pkg::LANES],
  input  logic                wide,
  output tdfm_pkg::match_t    match
);
  always_comb begin
    match = '0;
    for (int t = tdfm_pkg::LANES - 1; t >= 0; t--) begin
      if (res[t].hit) begin
        match.hit  = 1'b1;
        match.slot = res[t].slot;
        match.h    = tdfm_pkg::lane_h(2'(t), wide);
        match.v    = tdfm_pkg::lane_v(2'(t), wide);
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/tile_dedup_flip_match.sv
// Top level of the tile dedup block with flip matching.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_dedup_flip_match_macros.svh"
// Tile dedup with flip matching. A tile arrives as eight row items (tlast on
// the eighth). After the last row, four lanes (identity, h, v, both) scan
// the tile store together, one stored row per cycle from a single read port.
// A tile with no match is then written to the store unless it is full. No new
// rows are taken until the result has gone to the output register. A finished
// result waits in the output register while the next tile's rows come in.
// Search order of flips: 4bpp identity, v, h, both; 8bpp identity, h, v, both.
// The store needs no clearing; only written slots are read.
module tile_dedup_flip_match (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // pixel_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,       // row_pixels[63:0]
  input  logic        s_tlast,       // last_row
  input  logic [3:0]  s_tuser,       // palette_bank[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // tile_index[9:0], h_flip[10], v_flip[11], bank_out[15:12]
  output logic [1:0]  m_tuser        // status[1:0]
);
  localparam int MAX_TILES = tdfm_pkg::MAX_TILES_DEF;
  localparam int SW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int AW = SW + 3;
  localparam int RW = tdfm_pkg::ROW_W;

  tdfm_pkg::state_t state, state_next;

  logic pixel_mode;
  logic [RW-1:0] rowbuf [8];
  logic [RW-1:0] fwd [8];
  logic [RW-1:0] rev [8];
  logic [2:0] row_count;
  logic [tdfm_pkg::SLOT_W-1:0] stored_count;

  logic [RW-1:0] mem [1 << AW];
  logic [RW-1:0] rd_data;
  logic [tdfm_pkg::SLOT_W-1:0] rd_slot, p_slot;
  logic [2:0] rd_row, p_row, wr_row;
  logic p_valid;

  logic [3:0] bank;
  logic [9:0] res_index;
  logic res_h, res_v;
  tdfm_pkg::status_t res_status;

  logic accept, scan_last, is_full, lanes_clear;
  logic [RW-1:0] in_row;
  tdfm_pkg::lane_res_t lane_res [tdfm_pkg::LANES];
  tdfm_pkg::match_t match;

  assign accept    = s_tvalid && s_tready;
  assign in_row    = pixel_mode ? s_tdata : {32'd0, s_tdata[31:0]};
  assign scan_last = (rd_row == 3'd7) && (rd_slot == stored_count - 1'b1);
  assign is_full   = 32'(stored_count) >= MAX_TILES;
  assign lanes_clear = accept && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) pixel_mode <= 1'b1;
    else if (cfg_we) pixel_mode <= cfg_wdata;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tdfm_pkg::S_IDLE:
        if (accept && s_tlast)
          state_next = (stored_count == '0) ? tdfm_pkg::S_DECIDE : tdfm_pkg::S_SCAN;
      tdfm_pkg::S_SCAN:   if (scan_last) state_next = tdfm_pkg::S_DRAIN;
      tdfm_pkg::S_DRAIN:  state_next = tdfm_pkg::S_DECIDE;
      tdfm_pkg::S_DECIDE:
        state_next = (match.hit || is_full) ? tdfm_pkg::S_HOLD : tdfm_pkg::S_STORE;
      tdfm_pkg::S_STORE:  if (wr_row == 3'd7) state_next = tdfm_pkg::S_HOLD;
      tdfm_pkg::S_HOLD:   if (!m_tvalid || m_tready) state_next = tdfm_pkg::S_IDLE;
      default:            state_next = tdfm_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    case (state)
      tdfm_pkg::S_IDLE: s_tready = 1'b1;
      default:          s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tdfm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // row gathering and the two rotating copies of the tile
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (accept) begin
      if (s_tlast) row_count <= '0;
      else         row_count <= row_count + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !s_tlast) rowbuf[row_count] <= in_row;
    if (accept && s_tlast) begin
      bank <= pixel_mode ? 4'd0 : s_tuser;
      for (int r = 0; r < 7; r++) begin
        // missing rows of a short tile read as zero
        fwd[r] <= (3'(r) < row_count) ? (pixel_mode ? rowbuf[r] : {32'd0, rowbuf[r][31:0]})
                                      : '0;
        rev[r] <= (3'(r) < row_count) ? (pixel_mode ? rowbuf[r] : {32'd0, rowbuf[r][31:0]})
                                      : '0;
      end
      fwd[7] <= in_row;
      rev[7] <= in_row;
    end else if (p_valid) begin
      for (int r = 0; r < 8; r++) begin
        fwd[r] <= fwd[(r + 1) % 8];
        rev[r] <= rev[(r + 7) % 8];
      end
    end else if (state == tdfm_pkg::S_STORE) begin
      for (int r = 0; r < 8; r++) fwd[r] <= fwd[(r + 1) % 8];
    end
  end

  // store scan and write
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      rd_slot      <= '0;
      rd_row       <= '0;
      wr_row       <= '0;
      stored_count <= '0;
    end else begin
      p_valid <= (state == tdfm_pkg::S_SCAN);
      if (state == tdfm_pkg::S_IDLE) begin
        rd_slot <= '0;
        rd_row  <= '0;
        wr_row  <= '0;
      end else if (state == tdfm_pkg::S_SCAN) begin
        rd_row <= rd_row + 3'd1;
        if (rd_row == 3'd7) rd_slot <= rd_slot + 1'b1;
      end else if (state == tdfm_pkg::S_STORE) begin
        wr_row <= wr_row + 3'd1;
        if (wr_row == 3'd7) stored_count <= stored_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tdfm_pkg::S_STORE) mem[{SW'(stored_count), wr_row}] <= fwd[0];
    rd_data <= mem[{SW'(rd_slot), rd_row}];
    p_slot  <= rd_slot;
    p_row   <= rd_row;
  end

  for (genvar t = 0; t < tdfm_pkg::LANES; t++) begin : g_lane
    tdfm_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .clear    (lanes_clear),
      .valid    (p_valid),
      .row      (p_row),
      .slot     (p_slot),
      .stored   (rd_data),
      .fwd_head (fwd[0]),
      .rev_head (rev[7]),
      .h        (tdfm_pkg::lane_h(2'(t), pixel_mode)),
      .v        (tdfm_pkg::lane_v(2'(t), pixel_mode)),
      .wide     (pixel_mode),
      .res      (lane_res[t])
    );
  end

  tdfm_merge u_merge (
    .res   (lane_res),
    .wide  (pixel_mode),
    .match (match)
  );

  // result register
  always_ff @(posedge clk) begin
    if (state == tdfm_pkg::S_DECIDE) begin
      if (match.hit) begin
        res_index  <= match.slot[9:0];
        res_h      <= match.h;
        res_v      <= match.v;
        res_status <= tdfm_pkg::ST_MATCHED;
      end else if (is_full) begin
        res_index  <= '0;
        res_h      <= 1'b0;
        res_v      <= 1'b0;
        res_status <= tdfm_pkg::ST_FULL;
      end else begin
        res_index  <= stored_count[9:0];
        res_h      <= 1'b0;
        res_v      <= 1'b0;
        res_status <= tdfm_pkg::ST_STORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == tdfm_pkg::S_HOLD && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {bank, res_v, res_h, res_index};
      m_tuser  <= res_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `TDFM_ASSERT_IMPL(a_drained, state == tdfm_pkg::S_DECIDE, !p_valid)
  `TDFM_ASSERT_IMPL(a_full_zero, m_tvalid && m_tuser == tdfm_pkg::ST_FULL, m_tdata[11:0] == 12'd0)
  `TDFM_ASSERT_NEXT(a_store_grow, state == tdfm_pkg::S_STORE && wr_row == 3'd7,
                    stored_count == $past(stored_count) + 1'b1)
endmodule
`default_nettype wire
